// ----- hdl/gsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Gaussian spot pixel generator package
// Shared widths, register indexes, latencies and the exponential table builder.
// ----------------------------------------------------------------------------
package gsp_pkg;

   // Q11.12 magnitude of a normalized axis distance and its saturation value
   localparam int QMAG_BITS = 23;
   localparam logic [QMAG_BITS-1:0] QMAG_MAX = {QMAG_BITS{1'b1}};

   // Rounded square in Q.12
   localparam int SQ_BITS = 34;

   // Exponential argument limit, 6.25 in Q4.12
   localparam logic [15:0] ARG_LIMIT = 16'd25600;

   // Cycles through each pipeline section
   localparam int AXIS_LATENCY = 26;
   localparam int LUT_LATENCY  = 4;

   // Configuration register indexes
   typedef enum logic [3:0] {
      CSR_CENTER_COL = 4'd0,
      CSR_CENTER_ROW = 4'd1,
      CSR_SIGMA_COL  = 4'd2,
      CSR_SIGMA_ROW  = 4'd3
   } csr_index_type;

   localparam logic [63:0] ONE_Q30  = 64'd1073741824;
   localparam logic [63:0] HALF_Q30 = 64'd536870912;

   // One table entry: Taylor series of exp(-y) in Q0.30, squared six times
   function automatic logic [7:0] rom_entry(input logic [63:0] y);
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] prod;
      logic [63:0] scaled;
      sum  = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n <= 8; n++) begin
         prod = (term * y + HALF_Q30) >> 30;
         case (n)
            1: term = prod;
            2: term = prod / 2;
            3: term = prod / 3;
            4: term = prod / 4;
            5: term = prod / 5;
            6: term = prod / 6;
            7: term = prod / 7;
            default: term = prod / 8;
         endcase
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int i = 0; i < 6; i++) begin
         sum = (sum * sum + HALF_Q30) >> 30;
      end
      scaled = (64'd255 * sum + HALF_Q30) >> 30;
      return scaled[7:0];
   endfunction

endpackage

// ----- hdl/gsp_axis.sv -----
// ----------------------------------------------------------------------------
// Gaussian spot axis unit
// Normalizes one coordinate distance by its sigma with a one-bit-per-stage
// restoring divider, saturates the quotient, then squares and rounds the result to Q.12.
// ----------------------------------------------------------------------------
module gsp_axis (
   input  logic                         clock,
   input  logic [9:0]                   pos,
   input  logic [9:0]                   center,
   input  logic [15:0]                  sigma,
   output logic [gsp_pkg::SQ_BITS-1:0]  sq
);

   localparam int QB = gsp_pkg::QMAG_BITS;

   // Front end: distance, divisor, dividend and saturation check
   logic [9:0]  mag;
   logic [15:0] den;
   logic [28:0] num;
   logic        sat;

   always_comb begin
      mag = (pos >= center) ? (pos - center) : (center - pos);
      den = (sigma == 16'd0) ? 16'd1 : sigma;
      num = {mag, 19'd0} + {14'd0, den[15:1]};
      sat = ({10'd0, num} >= {den, 23'd0});
   end

   // Divider stage registers
   logic [15:0]   rem_ff [QB+1];
   logic [QB-1:0] lo_ff  [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic [15:0]   den_ff [QB+1];
   logic          sat_ff [QB+1];

   logic [15:0]   rem_in [QB];
   logic [QB-1:0] quo_in [QB];

   // One quotient bit per stage
   always_comb begin
      for (int i = 0; i < QB; i++) begin
         logic [16:0] t;
         t = {rem_ff[i], lo_ff[i][QB-1]};
         if (t >= {1'b0, den_ff[i]}) begin
            rem_in[i] = 16'(t - {1'b0, den_ff[i]});
            quo_in[i] = {quo_ff[i][QB-2:0], 1'b1};
         end else begin
            rem_in[i] = t[15:0];
            quo_in[i] = {quo_ff[i][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= {10'd0, num[28:23]};
      lo_ff[0]  <= num[22:0];
      quo_ff[0] <= '0;
      den_ff[0] <= den;
      sat_ff[0] <= sat;
      for (int i = 0; i < QB; i++) begin
         rem_ff[i+1] <= rem_in[i];
         lo_ff[i+1]  <= {lo_ff[i][QB-2:0], 1'b0};
         quo_ff[i+1] <= quo_in[i];
         den_ff[i+1] <= den_ff[i];
         sat_ff[i+1] <= sat_ff[i];
      end
   end

   // Saturate, square, then round to Q.12
   logic [QB-1:0]     qmag_in;
   logic [2*QB-1:0]   prod_ff;
   logic [gsp_pkg::SQ_BITS-1:0] sq_ff;

   assign qmag_in = sat_ff[QB] ? gsp_pkg::QMAG_MAX : quo_ff[QB];

   always_ff @(posedge clock) begin
      prod_ff <= (2*QB)'(qmag_in) * (2*QB)'(qmag_in);
      sq_ff   <= gsp_pkg::SQ_BITS'((prod_ff + (2*QB)'(2048)) >> 12);
   end

   assign sq = sq_ff;

endmodule

// ----- hdl/gsp_lut.sv -----
// ----------------------------------------------------------------------------
// Gaussian spot exponential lookup
// Scales the Q3.12 argument to a table index and reads the gray level table.
// ----------------------------------------------------------------------------
module gsp_lut #(
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic [14:0] arg,
   output logic [7:0]  gray
);

   localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int PW = 15 + DW;
   localparam int XW = PW - 10;
   localparam int MW = XW - 4;
   localparam int IW = $clog2(EXP_TABLE_DEPTH);

   // Constant table of gray levels
   logic [7:0] rom_w [EXP_TABLE_DEPTH];

   for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] Y = ((64'(k) * 64'd25) << 22) / 64'(EXP_TABLE_DEPTH);
      localparam logic [7:0]  V = gsp_pkg::rom_entry(Y);
      assign rom_w[k] = V;
   end

   logic [PW-1:0]  prod_ff;
   logic [XW-1:0]  x_ff;
   logic [MW-1:0]  est_ff;
   logic [IW-1:0]  idx_ff;
   logic [7:0]     gray_ff;

   logic [XW-1:0]    x_w;
   logic [XW+12:0]   recip_w;
   logic [MW+4:0]    back_w;
   logic [MW-1:0]    fix_w;
   logic [IW-1:0]    idx_in;

   // Divide by 25600: shift by 1024, then reciprocal of 25 with one correction
   always_comb begin
      x_w     = prod_ff[PW-1:10];
      recip_w = (XW+13)'(x_w) * (XW+13)'(5243);
      back_w  = (MW+5)'(est_ff) * (MW+5)'(25);
      fix_w   = (back_w > (MW+5)'(x_ff)) ? (est_ff - MW'(1)) : est_ff;
      if ((MW+1)'(fix_w) >= (MW+1)'(EXP_TABLE_DEPTH)) begin
         idx_in = IW'(EXP_TABLE_DEPTH - 1);
      end else begin
         idx_in = fix_w[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(arg) * PW'(EXP_TABLE_DEPTH);
      x_ff    <= x_w;
      est_ff  <= recip_w[XW+12:17];
      idx_ff  <= idx_in;
      gray_ff <= rom_w[idx_ff];
   end

   assign gray = gray_ff;

endmodule

// ----- hdl/gaussian_spot_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// Gaussian spot pixel generator
// Gives 255*exp(-a^2-b^2) for a pixel coordinate, one pixel per clock.
// ----------------------------------------------------------------------------
// Takes one pixel every clock (busy stays low) and returns its gray level on
// rsp_gray_value with rsp_strobe high for one cycle; the receiver cannot hold
// results off, so take each one as it comes. Most of the pipeline is the
// 23-stage divider that scales each axis distance by its sigma. Write the
// configuration registers (csr_ready is always high) only while no pixel is
// in flight.
module gaussian_spot_pixel_generator #(
   parameter int IMAGE_COLUMNS   = 1024,
   parameter int IMAGE_ROWS      = 1024,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_pixel_row,
   input  logic [9:0]  req_pixel_col,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_gray_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AL = gsp_pkg::AXIS_LATENCY;
   localparam int LL = gsp_pkg::LUT_LATENCY;
   localparam int PIPE_LATENCY = AL + LL + 2;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers
   logic [9:0]  center_col_ff;
   logic [9:0]  center_row_ff;
   logic [15:0] sigma_col_ff;
   logic [15:0] sigma_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= 10'd512;
         center_row_ff <= 10'd512;
         sigma_col_ff  <= 16'd30720;
         sigma_row_ff  <= 16'd25600;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gsp_pkg::CSR_CENTER_COL: center_col_ff <= csr_data[9:0];
            gsp_pkg::CSR_CENTER_ROW: center_row_ff <= csr_data[9:0];
            gsp_pkg::CSR_SIGMA_COL:  sigma_col_ff  <= csr_data;
            gsp_pkg::CSR_SIGMA_ROW:  sigma_row_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Capture the item and flag pixels outside the image
   logic [9:0] row_ff;
   logic [9:0] col_ff;
   logic       vld0_ff;
   logic       out0_ff;
   logic       outside_in;

   assign outside_in = (13'(req_pixel_row) >= 13'(IMAGE_ROWS)) ||
                       (13'(req_pixel_col) >= 13'(IMAGE_COLUMNS));

   always_ff @(posedge clock) begin
      row_ff <= req_pixel_row;
      col_ff <= req_pixel_col;
      out0_ff <= outside_in;
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= start && !busy;
      end
   end

   // Per-axis squared distances
   logic [gsp_pkg::SQ_BITS-1:0] sq_col_w;
   logic [gsp_pkg::SQ_BITS-1:0] sq_row_w;

   gsp_axis u_axis_col (
      .clock  (clock),
      .pos    (col_ff),
      .center (center_col_ff),
      .sigma  (sigma_col_ff),
      .sq     (sq_col_w)
   );

   gsp_axis u_axis_row (
      .clock  (clock),
      .pos    (row_ff),
      .center (center_row_ff),
      .sigma  (sigma_row_ff),
      .sq     (sq_row_w)
   );

   // Carry valid and outside flag alongside the axis units
   logic vld_a_ff [AL];
   logic out_a_ff [AL];

   always_ff @(posedge clock) begin
      out_a_ff[0] <= out0_ff;
      for (int i = 1; i < AL; i++) begin
         out_a_ff[i] <= out_a_ff[i-1];
      end
      if (reset) begin
         for (int i = 0; i < AL; i++) begin
            vld_a_ff[i] <= 1'b0;
         end
      end else begin
         vld_a_ff[0] <= vld0_ff;
         for (int i = 1; i < AL; i++) begin
            vld_a_ff[i] <= vld_a_ff[i-1];
         end
      end
   end

   // Sum, saturate and check the argument range
   logic [gsp_pkg::SQ_BITS:0] sum_w;
   logic [15:0]               arg_w;
   logic [14:0]               arg_ff;
   logic                      sum_vld_ff;
   logic                      sum_zero_ff;

   always_comb begin
      sum_w = (gsp_pkg::SQ_BITS+1)'(sq_col_w) + (gsp_pkg::SQ_BITS+1)'(sq_row_w);
      arg_w = (sum_w > (gsp_pkg::SQ_BITS+1)'(16'hFFFF)) ? 16'hFFFF : sum_w[15:0];
   end

   always_ff @(posedge clock) begin
      arg_ff      <= arg_w[14:0];
      sum_zero_ff <= out_a_ff[AL-1] || (arg_w >= gsp_pkg::ARG_LIMIT);
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else begin
         sum_vld_ff <= vld_a_ff[AL-1];
      end
   end

   // Table lookup
   logic [7:0] gray_w;

   gsp_lut #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_lut (
      .clock (clock),
      .arg   (arg_ff),
      .gray  (gray_w)
   );

   logic vld_l_ff  [LL];
   logic zero_l_ff [LL];

   always_ff @(posedge clock) begin
      zero_l_ff[0] <= sum_zero_ff;
      for (int i = 1; i < LL; i++) begin
         zero_l_ff[i] <= zero_l_ff[i-1];
      end
      if (reset) begin
         for (int i = 0; i < LL; i++) begin
            vld_l_ff[i] <= 1'b0;
         end
      end else begin
         vld_l_ff[0] <= sum_vld_ff;
         for (int i = 1; i < LL; i++) begin
            vld_l_ff[i] <= vld_l_ff[i-1];
         end
      end
   end

   // Output register: drop the level to zero for flagged items
   logic [7:0] gray_ff;
   logic       strobe_ff;

   always_ff @(posedge clock) begin
      gray_ff <= zero_l_ff[LL-1] ? 8'd0 : gray_w;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_l_ff[LL-1];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_gray_value = gray_ff;

   // Every accepted item leaves after the fixed pipeline latency; the strobe
   // rises at that edge and is seen at the next one
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(PIPE_LATENCY+1) rsp_strobe)
      else $error("item did not leave after pipeline latency");

   // A flagged item leaves as black
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (sum_vld_ff && sum_zero_ff) |-> ##(LL+1) (rsp_strobe && rsp_gray_value == 8'd0))
      else $error("flagged item left with nonzero gray level");

   // No strobe without an item accepted at the matching edge
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (sum_vld_ff == 1'b0) |-> ##(LL+1) (rsp_strobe == 1'b0))
      else $error("strobe without an item");

endmodule

// ----- verif/gaussian_spot_pixel_generator_checker.sv -----
// ----------------------------------------------------------------------------
// Gaussian spot pixel generator checker
// Watches the pixel, result and register channels, computes the expected gray
// level of every accepted pixel and compares it with the returned one.
// ----------------------------------------------------------------------------
module gaussian_spot_pixel_generator_checker #(
   parameter int IMAGE_COLUMNS   = 1024,
   parameter int IMAGE_ROWS      = 1024,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [9:0]  req_pixel_row,
   input  logic [9:0]  req_pixel_col,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_gray_value,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam logic [63:0] ONE_Q   = 64'd1073741824;
   localparam logic [63:0] HALF_Q  = 64'd536870912;
   localparam logic [63:0] MAG_SAT = 64'd8388607;
   localparam logic [63:0] X_LIMIT = 64'd25600;

   logic [7:0]  exp_table [EXP_TABLE_DEPTH];
   logic [9:0]  ctr_col;
   logic [9:0]  ctr_row;
   logic [15:0] spread_col;
   logic [15:0] spread_row;
   logic [7:0]  gray_queue [$];

   // exp table entry k: series of exp(-y) in Q0.30, then squared six times
   function automatic logic [7:0] exp_level(input logic [63:0] k);
      logic [63:0] y;
      logic [63:0] acc;
      logic [63:0] term;
      y    = ((k * 64'd25) << 22) / EXP_TABLE_DEPTH;
      acc  = ONE_Q;
      term = ONE_Q;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * y + HALF_Q) >> 30) / n;
         if (n % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      for (int i = 0; i < 6; i++) acc = (acc * acc + HALF_Q) >> 30;
      return 8'((64'd255 * acc + HALF_Q) >> 30);
   endfunction

   // rounded Q.12 square of one normalized axis distance
   function automatic logic [63:0] axis_sq(input logic [9:0] pos, input logic [9:0] ctr,
                                           input logic [15:0] spread);
      logic [63:0] mag;
      logic [63:0] den;
      logic [63:0] q;
      mag = (pos >= ctr) ? 64'(pos - ctr) : 64'(ctr - pos);
      den = (spread == 0) ? 64'd1 : 64'(spread);
      q   = ((mag << 19) + den / 2) / den;
      if (q > MAG_SAT) q = MAG_SAT;
      return (q * q + 64'd2048) >> 12;
   endfunction

   function automatic logic [7:0] spot_gray(input logic [9:0] row, input logic [9:0] col);
      logic [63:0] x;
      logic [63:0] idx;
      if (row >= IMAGE_ROWS || col >= IMAGE_COLUMNS) return 8'd0;
      x = axis_sq(col, ctr_col, spread_col) + axis_sq(row, ctr_row, spread_row);
      if (x > 64'hFFFF) x = 64'hFFFF;
      if (x >= X_LIMIT) return 8'd0;
      idx = x * EXP_TABLE_DEPTH / X_LIMIT;
      if (idx >= EXP_TABLE_DEPTH) idx = EXP_TABLE_DEPTH - 1;
      return exp_table[idx];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) exp_table[k] = exp_level(k);
      fail_count = 0;
      pending    = 0;
   end

   // track registers, queue expectations, compare results
   always @(posedge clock) begin
      if (reset) begin
         ctr_col    <= 10'd512;
         ctr_row    <= 10'd512;
         spread_col <= 16'd30720;
         spread_row <= 16'd25600;
         gray_queue.delete();
      end else begin
         if (rsp_strobe) begin
            if (gray_queue.size() == 0) begin
               report_mismatch($sformatf("gray %0d with no pixel waiting", rsp_gray_value));
            end else if (gray_queue[0] !== rsp_gray_value) begin
               report_mismatch($sformatf("gray %0d, expected %0d",
                                         rsp_gray_value, gray_queue[0]));
               void'(gray_queue.pop_front());
            end else begin
               void'(gray_queue.pop_front());
            end
         end
         if (start && !busy) gray_queue.push_back(spot_gray(req_pixel_row, req_pixel_col));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gsp_pkg::CSR_CENTER_COL: ctr_col <= csr_data[9:0];
               gsp_pkg::CSR_CENTER_ROW: ctr_row <= csr_data[9:0];
               gsp_pkg::CSR_SIGMA_COL:  spread_col <= csr_data;
               gsp_pkg::CSR_SIGMA_ROW:  spread_row <= csr_data;
               default: ;
            endcase
         end
      end
      pending = gray_queue.size();
   end

endmodule

// ----- verif/gaussian_spot_pixel_generator_test.sv -----
// ----------------------------------------------------------------------------
// Gaussian spot pixel generator test
// Drives directed and random pixels through several register settings, with
// random gaps on the pixel side; the checker predicts and compares each gray.
// ----------------------------------------------------------------------------
module gaussian_spot_pixel_generator_test;

   localparam int DRAIN_CYCLES = gsp_pkg::AXIS_LATENCY + gsp_pkg::LUT_LATENCY + 16;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [9:0]  req_pixel_row = '0;
   logic [9:0]  req_pixel_col = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_gray_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   bit          steady = 1'b0;

   always #4 clock = ~clock;

   gaussian_spot_pixel_generator u_top (.*);

   gaussian_spot_pixel_generator_checker u_checker (.*);

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // present one pixel; start stays high so the next one can follow at once
   task automatic send_pixel(input logic [9:0] row, input logic [9:0] col);
      while (!steady && $urandom_range(99) < 34) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_pixel_row <= row;
      req_pixel_col <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input gsp_pkg::csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // drop start and wait out every pixel in flight
   task automatic drain;
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_pixels(input int count, input logic [9:0] c_col,
                                input logic [9:0] c_row, input int reach);
      int dc;
      int dr;
      for (int i = 0; i < count; i++) begin
         steady = (i >= count / 3 && i < count / 2);
         if ($urandom_range(3) == 0) begin
            send_pixel(10'($urandom), 10'($urandom));
         end else begin
            dc = $urandom_range(2 * reach) - reach;
            dr = $urandom_range(2 * reach) - reach;
            send_pixel(10'(int'(c_row) + dr), 10'(int'(c_col) + dc));
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: center, corners, near-center, far out at reset setting
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd512, 10'd513);
      send_pixel(10'd511, 10'd512);
      send_pixel(10'd600, 10'd700);
      send_pixel(10'd300, 10'd400);
      send_pixel(10'd682, 10'd341);
      drain();

      // zero sigmas, extreme centers, bad register index
      write_reg(gsp_pkg::CSR_SIGMA_COL, 16'd0);
      write_reg(gsp_pkg::CSR_SIGMA_ROW, 16'd0);
      write_reg(gsp_pkg::CSR_CENTER_COL, 16'd0);
      write_reg(gsp_pkg::CSR_CENTER_ROW, 16'd1023);
      write_reg(gsp_pkg::csr_index_type'(4'd9), 16'hFFFF);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd1023, 10'd1);
      send_pixel(10'd0, 10'd1023);
      drain();

      // widest sigmas
      write_reg(gsp_pkg::CSR_SIGMA_COL, 16'hFFFF);
      write_reg(gsp_pkg::CSR_SIGMA_ROW, 16'hFFFF);
      write_reg(gsp_pkg::CSR_CENTER_COL, 16'd1023);
      write_reg(gsp_pkg::CSR_CENTER_ROW, 16'd0);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd512, 10'd512);
      drain();
      random_pixels(250, 10'd1023, 10'd0, 1023);
      drain();

      // random settings, pixels clustered near the spot
      for (int phase = 0; phase < 7; phase++) begin
         logic [9:0] cc;
         logic [9:0] cr;
         logic [15:0] sc;
         logic [15:0] sr;
         cc = 10'($urandom);
         cr = 10'($urandom);
         sc = (phase == 0) ? 16'd1 : 16'($urandom_range(16'hFFFF, 1) >> $urandom_range(10));
         sr = (phase == 1) ? 16'd1 : 16'($urandom_range(16'hFFFF, 1) >> $urandom_range(10));
         write_reg(gsp_pkg::CSR_CENTER_COL, 16'(cc) | 16'($urandom_range(63) << 10));
         write_reg(gsp_pkg::CSR_CENTER_ROW, 16'(cr));
         write_reg(gsp_pkg::CSR_SIGMA_COL, sc);
         write_reg(gsp_pkg::CSR_SIGMA_ROW, sr);
         random_pixels(200, cc, cr, 1 + ((int'(sc) + int'(sr)) >> 7));
         drain();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/gsp_pkg.sv
hdl/gsp_axis.sv
hdl/gsp_lut.sv
hdl/gaussian_spot_pixel_generator.sv
verif/gaussian_spot_pixel_generator_checker.sv
verif/gaussian_spot_pixel_generator_test.sv
